### src/eeps_pkg.sv
// Shared types and codes for the I2C EEPROM page sequencer.
package eeps_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;
  localparam logic [1:0] MODE_EVENT = 2'd3;

  localparam logic [3:0] ST_START_SENT   = 4'd0;
  localparam logic [3:0] ST_RESTART_SENT = 4'd1;
  localparam logic [3:0] ST_AW_ACK       = 4'd2;
  localparam logic [3:0] ST_AW_NACK      = 4'd3;
  localparam logic [3:0] ST_DATA_ACK     = 4'd4;
  localparam logic [3:0] ST_AR_ACK       = 4'd5;
  localparam logic [3:0] ST_RX_ACK       = 4'd6;
  localparam logic [3:0] ST_RX_NACK      = 4'd7;

  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_START    = 4'd1;
  localparam logic [3:0] CMD_ADDR_WR  = 4'd2;
  localparam logic [3:0] CMD_ADDR_RD  = 4'd3;
  localparam logic [3:0] CMD_SEND     = 4'd4;
  localparam logic [3:0] CMD_RESTART  = 4'd5;
  localparam logic [3:0] CMD_RX_ACK   = 4'd6;
  localparam logic [3:0] CMD_RX_NACK  = 4'd7;
  localparam logic [3:0] CMD_STOP     = 4'd8;

  localparam logic [1:0] ACC_OK        = 2'd0;
  localparam logic [1:0] ACC_MISALIGN  = 2'd1;
  localparam logic [1:0] ACC_BUSY      = 2'd2;
  localparam logic [1:0] ACC_IDLE_EVT  = 2'd3;

  localparam logic [7:0] ERASE_BYTE   = 8'hFF;
  localparam logic [7:0] PAGE_SIZE_RST = 8'd64;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  device_addr;
    logic [15:0] page_addr;
    logic [3:0]  bus_status;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] accept_code;
    logic [3:0] bus_command;
    logic [6:0] target_addr;
    logic [7:0] tx_byte;
    logic       write_byte_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [6:0] read_index;
    logic       done_res;
  } out_word_t;

endpackage

### src/eeps_if.sv
// Valid/ready channel interfaces for request and result words.
interface eeps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  device_addr;
  logic [15:0] page_addr;
  logic [3:0]  bus_status;
  logic [7:0]  rx_byte;
  logic [7:0]  write_byte;

  modport source (output valid, mode, device_addr, page_addr, bus_status, rx_byte,
                  write_byte, input ready);
  modport sink (input valid, mode, device_addr, page_addr, bus_status, rx_byte,
                write_byte, output ready);
endinterface

interface eeps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] accept_code;
  logic [3:0] bus_command;
  logic [6:0] target_addr;
  logic [7:0] tx_byte;
  logic       write_byte_taken;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [6:0] read_index;
  logic       done_res;

  modport source (output valid, accept_code, bus_command, target_addr, tx_byte,
                  write_byte_taken, read_valid, read_byte, read_index, done_res,
                  input ready);
  modport sink (input valid, accept_code, bus_command, target_addr, tx_byte,
                write_byte_taken, read_valid, read_byte, read_index, done_res,
                output ready);
endinterface

### src/i2c_eeprom_page_sequencer.sv
// Top level: input register, sequencer core and result register.
// Each word makes a single pass from the input register to the result register.
// Throughput: one word per cycle while the result channel is not stalled.
// A stalled result blocks input once the input register also holds a word.
// Reset (rst_n low, synchronous): idle, counters and addresses zero, page size 64.
module i2c_eeprom_page_sequencer #(
  parameter int MAX_PAGE_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  eeps_in_if.sink    in_ch,
  eeps_out_if.source out_ch
);
  import eeps_pkg::*;

  logic      in_v_r;
  in_word_t  in_r;
  logic      out_v_r;
  out_word_t res_r;
  out_word_t res;
  logic      adv;
  logic      in_take;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  eeps_core #(.MAX_PAGE_BYTES(MAX_PAGE_BYTES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (adv),
    .req       (in_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
    if (in_take) begin
      in_r.mode        <= in_ch.mode;
      in_r.device_addr <= in_ch.device_addr;
      in_r.page_addr   <= in_ch.page_addr;
      in_r.bus_status  <= in_ch.bus_status;
      in_r.rx_byte     <= in_ch.rx_byte;
      in_r.write_byte  <= in_ch.write_byte;
    end
    if (adv) res_r <= res;
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.accept_code      = res_r.accept_code;
  assign out_ch.bus_command      = res_r.bus_command;
  assign out_ch.target_addr      = res_r.target_addr;
  assign out_ch.tx_byte          = res_r.tx_byte;
  assign out_ch.write_byte_taken = res_r.write_byte_taken;
  assign out_ch.read_valid       = res_r.read_valid;
  assign out_ch.read_byte        = res_r.read_byte;
  assign out_ch.read_index       = res_r.read_index;
  assign out_ch.done_res         = res_r.done_res;

endmodule

### src/eeps_core.sv
// Sequencer state and next-command logic for one word per cycle while step_en is high.
module eeps_core #(
  parameter int MAX_PAGE_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               step_en,
  input  eeps_pkg::in_word_t req,
  output eeps_pkg::out_word_t res
);
  import eeps_pkg::*;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_ERASE = 2'd3
  } op_t;

  localparam logic [7:0] MaxPage = 8'(MAX_PAGE_BYTES);

  logic [7:0]  page_size_r;
  op_t         op_r, op_nxt;
  logic [8:0]  step_r, step_nxt;
  logic [7:0]  bytes_r, bytes_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [6:0]  slave_r, slave_nxt;

  logic [7:0]  psz;
  logic [8:0]  psz_p3, psz_p4;
  logic [8:0]  step_inc;
  logic        misaligned, busy;
  out_word_t   r;

  always_comb begin
    psz = page_size_r;
    if (psz == 8'd0) psz = 8'd1;
    if (psz > MaxPage) psz = MaxPage;
  end

  assign psz_p3     = {1'b0, psz} + 9'd3;
  assign psz_p4     = {1'b0, psz} + 9'd4;
  assign step_inc   = step_r + 9'd1;
  assign misaligned = (req.page_addr & {8'h00, psz - 8'd1}) != 16'h0000;
  assign busy       = op_r != OP_IDLE;

  always_comb begin
    op_nxt    = op_r;
    step_nxt  = step_r;
    bytes_nxt = bytes_r;
    addr_nxt  = addr_r;
    slave_nxt = slave_r;
    r = '0;
    if (req.mode != MODE_EVENT) begin
      if (req.mode == MODE_ERASE && busy) begin
        r.accept_code = ACC_BUSY;
      end else if (misaligned) begin
        r.accept_code = ACC_MISALIGN;
      end else if (busy) begin
        r.accept_code = ACC_BUSY;
      end else begin
        unique case (req.mode)
          MODE_READ:  op_nxt = OP_READ;
          MODE_WRITE: op_nxt = OP_WRITE;
          default:    op_nxt = OP_ERASE;
        endcase
        step_nxt      = '0;
        bytes_nxt     = '0;
        addr_nxt      = req.page_addr;
        slave_nxt     = req.device_addr;
        r.bus_command = CMD_START;
      end
    end else if (op_r == OP_IDLE) begin
      r.accept_code = ACC_IDLE_EVT;
    end else if (op_r == OP_READ) begin
      case (req.bus_status)
        ST_START_SENT: begin
          r.bus_command = CMD_ADDR_WR;
          step_nxt = step_inc;
        end
        ST_RESTART_SENT: begin
          r.bus_command = CMD_ADDR_RD;
          step_nxt = step_inc;
        end
        ST_AW_ACK: begin
          r.bus_command = CMD_SEND;
          r.tx_byte = addr_r[15:8];
          step_nxt = step_inc;
        end
        ST_AW_NACK: begin
          r.bus_command = CMD_RESTART;
          step_nxt = '0;
        end
        ST_DATA_ACK: begin
          if (step_r == 9'd2) begin
            r.bus_command = CMD_SEND;
            r.tx_byte = addr_r[7:0];
          end else if (step_r == 9'd3) begin
            r.bus_command = CMD_START;
          end
          step_nxt = step_inc;
        end
        ST_AR_ACK, ST_RX_ACK: begin
          r.bus_command = (step_r >= psz_p4) ? CMD_RX_NACK : CMD_RX_ACK;
          if (req.bus_status == ST_RX_ACK) begin
            r.read_valid = 1'b1;
            r.read_byte  = req.rx_byte;
            r.read_index = bytes_r[6:0];
            bytes_nxt    = bytes_r + 8'd1;
          end
          addr_nxt = addr_r + 16'd1;
          step_nxt = step_inc;
        end
        ST_RX_NACK: begin
          r.bus_command = CMD_STOP;
          r.read_valid  = 1'b1;
          r.read_byte   = req.rx_byte;
          r.read_index  = bytes_r[6:0];
          r.done_res    = 1'b1;
          bytes_nxt     = '0;
          step_nxt      = '0;
          op_nxt        = OP_IDLE;
        end
        default: step_nxt = step_inc;
      endcase
    end else begin
      case (req.bus_status)
        ST_START_SENT: begin
          r.bus_command = CMD_ADDR_WR;
          step_nxt = step_inc;
        end
        ST_AW_ACK: begin
          r.bus_command = CMD_SEND;
          r.tx_byte = addr_r[15:8];
          step_nxt = step_inc;
        end
        ST_AW_NACK: begin
          r.bus_command = CMD_RESTART;
          step_nxt = '0;
        end
        ST_DATA_ACK: begin
          if (step_r == 9'd2) begin
            r.bus_command = CMD_SEND;
            r.tx_byte = addr_r[7:0];
            step_nxt = step_inc;
          end else if (step_r < psz_p3) begin
            r.bus_command = CMD_SEND;
            if (op_r == OP_WRITE) begin
              r.tx_byte = req.write_byte;
              r.write_byte_taken = 1'b1;
            end else begin
              r.tx_byte = ERASE_BYTE;
            end
            addr_nxt = addr_r + 16'd1;
            step_nxt = step_inc;
          end else begin
            r.bus_command = CMD_STOP;
            r.done_res = 1'b1;
            step_nxt = '0;
            op_nxt = OP_IDLE;
          end
        end
        default: step_nxt = step_inc;
      endcase
    end
    if (r.bus_command == CMD_START || r.bus_command == CMD_ADDR_WR ||
        r.bus_command == CMD_ADDR_RD || r.bus_command == CMD_RESTART) begin
      r.target_addr = slave_nxt;
    end
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= PAGE_SIZE_RST;
      op_r        <= OP_IDLE;
      step_r      <= '0;
      bytes_r     <= '0;
      addr_r      <= '0;
      slave_r     <= '0;
    end else begin
      if (cfg_we) page_size_r <= cfg_wdata;
      if (step_en) begin
        op_r    <= op_nxt;
        step_r  <= step_nxt;
        bytes_r <= bytes_nxt;
        addr_r  <= addr_nxt;
        slave_r <= slave_nxt;
      end
    end
  end

endmodule

### dv/tb_i2c_eeprom_page_sequencer.sv
// Self-checking testbench for the I2C EEPROM page sequencer, with a predictor and handshake traffic.
module tb_i2c_eeprom_page_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import eeps_pkg::*;

  localparam int          MAX_PAGE       = 128;
  localparam int          RANDOM_ITEMS   = 1150;
  localparam int          PHASE_ITEMS    = 120;
  localparam int          HOLD_LEN       = 200;
  localparam int          HOLD_AFTER     = 400;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [3:0]  ST_OTHER       = 4'd8;

  typedef enum logic [1:0] {OP_IDLE, OP_READ, OP_WRITE, OP_ERASE} op_t;

  typedef struct packed {
    logic [7:0]  page_size;
    op_t         operation;
    logic [8:0]  step;
    logic [7:0]  byte_cnt;
    logic [15:0] mem_addr;
    logic [6:0]  slave;
  } seq_model_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  eeps_in_if  in_ch ();
  eeps_out_if out_ch ();

  i2c_eeprom_page_sequencer #(.MAX_PAGE_BYTES(MAX_PAGE)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #4 clk = ~clk;

  seq_model_t chk_model;
  seq_model_t gen_model;
  in_word_t   request_words[$];
  out_word_t  predicted_replies[$];
  logic [3:0] last_cmd;

  int  words_offered;
  int  words_in;
  int  words_out;
  int  read_bytes;
  int  ops_done;
  int  cfg_writes;
  int  mismatches;
  int  quiet_cycles;
  int  burst_left;
  int  gap_left;
  int  rx_hold;
  bit  long_hold_done;
  logic        in_fire;
  logic [15:0] rx_cycle;

  function automatic int unsigned eff_page(logic [7:0] p);
    if (p == 8'd0) return 1;
    if (p > MAX_PAGE) return MAX_PAGE;
    return p;
  endfunction

  function automatic out_word_t sequence_reply(inout seq_model_t m, input in_word_t w);
    out_word_t   r;
    int unsigned psz;
    logic        misaligned;
    logic        busy;
    r = '0;
    psz = eff_page(m.page_size);
    if (w.mode != MODE_EVENT) begin
      misaligned = (w.page_addr & 16'(psz - 1)) != 16'd0;
      busy = (m.operation != OP_IDLE);
      if (w.mode == MODE_ERASE && busy) r.accept_code = ACC_BUSY;
      else if (misaligned) r.accept_code = ACC_MISALIGN;
      else if (busy) r.accept_code = ACC_BUSY;
      else begin
        case (w.mode)
          MODE_READ:  m.operation = OP_READ;
          MODE_WRITE: m.operation = OP_WRITE;
          default:    m.operation = OP_ERASE;
        endcase
        m.step = '0;
        m.byte_cnt = '0;
        m.mem_addr = w.page_addr;
        m.slave = w.device_addr;
        r.bus_command = CMD_START;
      end
    end else if (m.operation == OP_IDLE) begin
      r.accept_code = ACC_IDLE_EVT;
    end else if (m.operation == OP_READ) begin
      case (w.bus_status)
        ST_START_SENT: begin
          r.bus_command = CMD_ADDR_WR;
          m.step = m.step + 9'd1;
        end
        ST_RESTART_SENT: begin
          r.bus_command = CMD_ADDR_RD;
          m.step = m.step + 9'd1;
        end
        ST_AW_ACK: begin
          r.bus_command = CMD_SEND;
          r.tx_byte = m.mem_addr[15:8];
          m.step = m.step + 9'd1;
        end
        ST_AW_NACK: begin
          r.bus_command = CMD_RESTART;
          m.step = '0;
        end
        ST_DATA_ACK: begin
          if (m.step == 9'd2) begin
            r.bus_command = CMD_SEND;
            r.tx_byte = m.mem_addr[7:0];
          end else if (m.step == 9'd3) begin
            r.bus_command = CMD_START;
          end
          m.step = m.step + 9'd1;
        end
        ST_AR_ACK, ST_RX_ACK: begin
          r.bus_command = (int'(m.step) >= psz + 4) ? CMD_RX_NACK : CMD_RX_ACK;
          if (w.bus_status == ST_RX_ACK) begin
            r.read_valid = 1'b1;
            r.read_byte = w.rx_byte;
            r.read_index = m.byte_cnt[6:0];
            m.byte_cnt = m.byte_cnt + 8'd1;
          end
          m.mem_addr = m.mem_addr + 16'd1;
          m.step = m.step + 9'd1;
        end
        ST_RX_NACK: begin
          r.bus_command = CMD_STOP;
          r.read_valid = 1'b1;
          r.read_byte = w.rx_byte;
          r.read_index = m.byte_cnt[6:0];
          m.byte_cnt = '0;
          m.step = '0;
          m.operation = OP_IDLE;
          r.done_res = 1'b1;
        end
        default: m.step = m.step + 9'd1;
      endcase
    end else begin
      case (w.bus_status)
        ST_START_SENT: begin
          r.bus_command = CMD_ADDR_WR;
          m.step = m.step + 9'd1;
        end
        ST_AW_ACK: begin
          r.bus_command = CMD_SEND;
          r.tx_byte = m.mem_addr[15:8];
          m.step = m.step + 9'd1;
        end
        ST_AW_NACK: begin
          r.bus_command = CMD_RESTART;
          m.step = '0;
        end
        ST_DATA_ACK: begin
          if (m.step == 9'd2) begin
            r.bus_command = CMD_SEND;
            r.tx_byte = m.mem_addr[7:0];
            m.step = m.step + 9'd1;
          end else if (int'(m.step) < psz + 3) begin
            r.bus_command = CMD_SEND;
            if (m.operation == OP_WRITE) begin
              r.tx_byte = w.write_byte;
              r.write_byte_taken = 1'b1;
            end else begin
              r.tx_byte = ERASE_BYTE;
            end
            m.mem_addr = m.mem_addr + 16'd1;
            m.step = m.step + 9'd1;
          end else begin
            r.bus_command = CMD_STOP;
            m.step = '0;
            m.operation = OP_IDLE;
            r.done_res = 1'b1;
          end
        end
        default: m.step = m.step + 9'd1;
      endcase
    end
    if (r.bus_command inside {CMD_START, CMD_ADDR_WR, CMD_ADDR_RD, CMD_RESTART})
      r.target_addr = m.slave;
    return r;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.mode        = 2'($urandom_range(0, 3));
    w.device_addr = 7'($urandom);
    w.page_addr   = 16'($urandom);
    w.bus_status  = 4'($urandom_range(0, 8));
    w.rx_byte     = 8'($urandom);
    w.write_byte  = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t event_word(logic [3:0] st);
    in_word_t w;
    w = rand_word();
    w.mode = MODE_EVENT;
    w.bus_status = st;
    return w;
  endfunction

  function automatic in_word_t mk_event(logic [3:0] st, logic [7:0] rx, logic [7:0] wb);
    in_word_t w;
    w = event_word(st);
    w.rx_byte = rx;
    w.write_byte = wb;
    return w;
  endfunction

  function automatic in_word_t start_word(logic [1:0] mode, logic aligned);
    in_word_t w;
    w = rand_word();
    w.mode = mode;
    if (aligned) w.page_addr = w.page_addr & ~16'(eff_page(gen_model.page_size) - 1);
    return w;
  endfunction

  function automatic in_word_t mk_start(logic [1:0] mode, logic [6:0] dev, logic [15:0] page);
    in_word_t w;
    w = rand_word();
    w.mode = mode;
    w.device_addr = dev;
    w.page_addr = page;
    return w;
  endfunction

  task automatic offer(in_word_t w);
    out_word_t r;
    r = sequence_reply(gen_model, w);
    if (r.bus_command != CMD_NONE) last_cmd = r.bus_command;
    request_words.push_back(w);
    words_offered++;
  endtask

  task automatic drain();
    while (gen_model.operation != OP_IDLE)
      offer(event_word(gen_model.operation == OP_READ ? ST_RX_NACK : ST_DATA_ACK));
  endtask

  task automatic run_op(logic [1:0] mode, int noise_pct);
    int         guard;
    logic [3:0] st;
    offer(start_word(mode, 1'b1));
    guard = 0;
    while (gen_model.operation != OP_IDLE && guard < eff_page(gen_model.page_size) + 24) begin
      guard++;
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       offer(rand_word());
          1:       offer(start_word(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1))));
          default: offer(event_word(ST_AW_NACK));
        endcase
      end else begin
        case (last_cmd)
          CMD_START:   st = (gen_model.step == 9'd0) ? ST_START_SENT : ST_RESTART_SENT;
          CMD_ADDR_WR: st = ($urandom_range(0, 7) == 0) ? ST_AW_NACK : ST_AW_ACK;
          CMD_ADDR_RD: st = ST_AR_ACK;
          CMD_SEND:    st = ST_DATA_ACK;
          CMD_RESTART: st = ST_START_SENT;
          CMD_RX_ACK:  st = ST_RX_ACK;
          CMD_RX_NACK: st = ST_RX_NACK;
          default:     st = (gen_model.operation == OP_READ) ? ST_RX_NACK : ST_DATA_ACK;
        endcase
        offer(event_word(st));
      end
    end
    drain();
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (request_words.size() != 0 || in_ch.valid || predicted_replies.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_page_size(logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    chk_model.page_size = v;
    gen_model.page_size = v;
    cfg_writes++;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin : request_driver
    in_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (request_words.size() != 0) begin
        w = request_words.pop_front();
        in_ch.mode        <= w.mode;
        in_ch.device_addr <= w.device_addr;
        in_ch.page_addr   <= w.page_addr;
        in_ch.bus_status  <= w.bus_status;
        in_ch.rx_byte     <= w.rx_byte;
        in_ch.write_byte  <= w.write_byte;
        in_ch.valid       <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    rx_cycle <= rx_cycle + 16'd1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else if (!long_hold_done && words_in >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      rx_hold = HOLD_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_cycle[9:7])
        3'd1:    out_ch.ready <= rx_cycle[0];
        3'd2:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        3'd3:    out_ch.ready <= 1'($urandom_range(0, 1));
        3'd5:    out_ch.ready <= (rx_cycle[3:0] < 4'd12);
        3'd6:    out_ch.ready <= ($urandom_range(0, 7) == 0);
        3'd7:    out_ch.ready <= (rx_cycle[5:4] != 2'b11);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : reply_monitor
    in_word_t  w;
    out_word_t exp_w;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        w.mode        = in_ch.mode;
        w.device_addr = in_ch.device_addr;
        w.page_addr   = in_ch.page_addr;
        w.bus_status  = in_ch.bus_status;
        w.rx_byte     = in_ch.rx_byte;
        w.write_byte  = in_ch.write_byte;
        predicted_replies.push_back(sequence_reply(chk_model, w));
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (predicted_replies.size() == 0) begin
          $error("result word with no pending expectation");
          mismatches++;
        end else begin
          exp_w = predicted_replies.pop_front();
          if (exp_w.read_valid) read_bytes++;
          if (exp_w.done_res) ops_done++;
          check_field("accept_code", 16'(exp_w.accept_code), 16'(out_ch.accept_code));
          check_field("bus_command", 16'(exp_w.bus_command), 16'(out_ch.bus_command));
          check_field("target_addr", 16'(exp_w.target_addr), 16'(out_ch.target_addr));
          check_field("tx_byte", 16'(exp_w.tx_byte), 16'(out_ch.tx_byte));
          check_field("write_byte_taken", 16'(exp_w.write_byte_taken),
                      16'(out_ch.write_byte_taken));
          check_field("read_valid", 16'(exp_w.read_valid), 16'(out_ch.read_valid));
          check_field("read_byte", 16'(exp_w.read_byte), 16'(out_ch.read_byte));
          check_field("read_index", 16'(exp_w.read_index), 16'(out_ch.read_index));
          check_field("done_res", 16'(exp_w.done_res), 16'(out_ch.done_res));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_i2c_eeprom_page_sequencer NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned size_list[$];
    int          size_idx;
    int          directed_words;
    int          phase_mark;
    int          pick;
    size_list = '{4, 128, 1, 8, 2, 64, 16, 32, 1, 128, 2};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.device_addr = '0;
    in_ch.page_addr = '0;
    in_ch.bus_status = '0;
    in_ch.rx_byte = '0;
    in_ch.write_byte = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    rx_cycle = '0;
    burst_left = 1;
    gap_left = 0;
    rx_hold = 0;
    long_hold_done = 1'b0;
    quiet_cycles = 0;
    last_cmd = CMD_NONE;
    chk_model = '0;
    chk_model.page_size = PAGE_SIZE_RST;
    gen_model = chk_model;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset page size: rejects only
    offer(mk_event(ST_OTHER, 8'hFF, 8'h00));
    offer(mk_start(MODE_READ, 7'h00, 16'h0020));
    offer(mk_start(MODE_WRITE, 7'h7F, 16'hFFFF));
    offer(mk_start(MODE_ERASE, 7'h2A, 16'h0001));
    wait_quiet();
    write_page_size(8'd1);

    // one-byte read, with starts while busy and nack held past the end
    offer(mk_start(MODE_READ, 7'h7F, 16'hFFFF));
    offer(event_word(ST_START_SENT));
    offer(event_word(ST_AW_ACK));
    offer(event_word(ST_DATA_ACK));
    offer(event_word(ST_DATA_ACK));
    offer(mk_start(MODE_ERASE, 7'h01, 16'h0003));
    offer(mk_start(MODE_READ, 7'h02, 16'h0000));
    offer(event_word(ST_RESTART_SENT));
    offer(mk_event(ST_AR_ACK, 8'h5A, 8'h00));
    offer(mk_event(ST_RX_ACK, 8'h00, 8'hFF));
    offer(mk_event(ST_RX_NACK, 8'hFF, 8'h00));

    // write with an address nack and an unknown status
    offer(mk_start(MODE_WRITE, 7'h00, 16'h0000));
    offer(event_word(ST_START_SENT));
    offer(event_word(ST_AW_NACK));
    offer(event_word(ST_START_SENT));
    offer(event_word(ST_AW_ACK));
    offer(mk_event(ST_DATA_ACK, 8'h00, 8'h00));
    offer(mk_event(ST_DATA_ACK, 8'hFF, 8'hFF));
    offer(event_word(ST_OTHER));
    drain();

    run_op(MODE_ERASE, 0);
    directed_words = words_offered;

    size_idx = 0;
    while (words_offered - directed_words < RANDOM_ITEMS) begin
      wait_quiet();
      write_page_size(8'(size_list[size_idx % size_list.size()]));
      size_idx++;
      phase_mark = words_offered;
      while (words_offered - phase_mark < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          run_op(2'($urandom_range(0, 2)), (pick == 6) ? 15 : 2);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 4)) offer(rand_word());
          drain();
        end else if (pick == 8) begin
          offer(start_word(2'($urandom_range(0, 2)), 1'b0));
          drain();
        end else begin
          offer(event_word(4'($urandom_range(0, 8))));
        end
      end
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    $display("Run covered %0d request words and %0d result words over %0d page-size settings,",
             words_in, words_out, cfg_writes);
    $display("with %0d bytes read back and %0d page operations completed.", read_bytes, ops_done);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("tb_i2c_eeprom_page_sequencer OK");
    end else begin
      $display("tb_i2c_eeprom_page_sequencer NOT OK");
    end
    $finish;
  end

endmodule
